FILE: design/i2t_pkg.sv
`timescale 1ns / 1ps

package i2t_pkg;

    localparam int FRAC_BITS = 24;

    localparam int CNT_W  = 31;
    localparam int TICK_W = 16;
    localparam int LVL_W  = 31;
    localparam int ACC_W  = 32;
    localparam int FLAG_W = 3;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 3;

    localparam int MUL_W     = 32;
    localparam int MUL_STEPS = MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = TICK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MUL_W-1:0]   NOMINAL   = MUL_W'(1) << FRAC_BITS;
    localparam logic [2*MUL_W-1:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [IDX_W-1:0] CFG_CYCLE_LENGTH = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CHECK_PERIOD = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CHECK_PHASE  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_WARN_LEVEL   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_ALARM_LEVEL  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TRIP_LEVEL   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_LEVEL_ENABLE = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SAMPLE_TIME  = 3'd7;

    localparam logic [FLAG_W-1:0] EN_WARN_ONLY = 3'd1;
    localparam logic [FLAG_W-1:0] EN_ALARM_MAX = 3'd3;

    localparam logic [TICK_W-1:0] CYCLE_LENGTH_RST = 16'd999;
    localparam logic [TICK_W-1:0] CHECK_PERIOD_RST = 16'd1;
    localparam logic [LVL_W-1:0]  LEVEL_RST        = {LVL_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_MUL,
        ST_MUL_DONE,
        ST_FLAGS,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MP_TIME,
        MP_POWER,
        MP_VALUE
    } mul_phase_t;

endpackage

FILE: design/i2t_overload_protection.sv
`timescale 1ns / 1ps

// i2t thermal overload protection. Each tick beat carries a Q24 rms current and
// returns one result beat; a clear beat drops the selected live and sticky flags
// and skips to the output state. A tick steps the wrapping tick counter and finds
// counter mod check_period with a bit-serial divider, skipped at check_period zero.
// A tick on an evaluation slot with rms above nominal or a positive accumulator
// runs three 32-step passes of one shift-add multiplier (count * sample_time,
// (rms - 1) * (rms + 1), then time * power), else clears count and accumulator.
// The next beat is taken while a result still waits.
module i2t_overload_protection
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             op,
    input  logic [30:0]                      rms_current,
    input  logic [2:0]                       clear_mask,

    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [2:0]                       live_flags,
    output logic [2:0]                       sticky_flags,
    output logic signed [31:0]               overload_value,
    output logic                             evaluated,

    input  logic                             cfg_we,
    input  logic [i2t_pkg::IDX_W-1:0]        cfg_index,
    input  logic [i2t_pkg::CFG_W-1:0]        cfg_data
);

    localparam int MW = i2t_pkg::MUL_W;

    i2t_pkg::state_t     state_reg, state_next;
    i2t_pkg::mul_phase_t phase_reg, phase_next;

    logic [15:0] cycle_length_reg, check_period_reg, check_phase_reg;
    logic [30:0] warn_level_reg, alarm_level_reg, trip_level_reg, sample_time_reg;
    logic [2:0]  level_enable_reg;

    logic [15:0]        tick_reg, tick_next;
    logic [30:0]        count_reg, count_next;
    logic signed [31:0] acc_reg, acc_next;
    logic [2:0]         live_reg, live_next;
    logic [2:0]         sticky_reg, sticky_next;
    logic               result_valid_reg, result_valid_next;

    logic [30:0] rms_reg, rms_next;
    logic        ev_reg, ev_next;

    logic [15:0]                    rem_reg, rem_next;
    logic [15:0]                    dvd_reg, dvd_next;
    logic [i2t_pkg::DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    logic [MW-1:0]                  mul_a_reg, mul_a_next;
    logic [MW-1:0]                  mul_hi_reg, mul_hi_next;
    logic [MW-1:0]                  mul_lo_reg, mul_lo_next;
    logic [i2t_pkg::MUL_CNT_W-1:0]  mul_cnt_reg, mul_cnt_next;
    logic [30:0]                    time_reg, time_next;
    logic                           neg_reg, neg_next;

    logic [2:0]         out_live_reg, out_live_next;
    logic [2:0]         out_sticky_reg, out_sticky_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_ev_reg, out_ev_next;

    logic               accept;
    logic               out_free;
    logic [15:0]        tick_step;
    logic [16:0]        div_shift;
    logic [17:0]        div_trial;
    logic               div_last;
    logic               mul_last;
    logic [MW:0]        mul_sum;
    logic [2*MW-1:0]    mul_prod;
    logic [2*MW-1:0]    mul_round;
    logic [39:0]        q_floor;
    logic [39:0]        q_ceil;
    logic               over_nominal;
    logic               acc_pos;
    logic               hold;
    logic [30:0]        count_step;
    logic               rms_below;
    logic [2:0]         live_eval;
    logic               acc_nonneg;

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == i2t_pkg::ST_IDLE);
    assign out_free   = !result_valid_reg || result_ready;

    assign tick_step = (tick_reg < cycle_length_reg) ? tick_reg + 16'd1 : 16'd0;

    assign div_shift = {rem_reg, dvd_reg[15]};
    assign div_trial = {1'b0, div_shift} - {2'b00, check_period_reg};
    assign div_last  = (div_cnt_reg == i2t_pkg::DIV_CNT_W'(i2t_pkg::DIV_STEPS - 1));

    assign mul_sum   = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mul_a_reg} : {(MW+1){1'b0}});
    assign mul_last  = (mul_cnt_reg == i2t_pkg::MUL_CNT_W'(i2t_pkg::MUL_STEPS - 1));
    assign mul_prod  = {mul_hi_reg, mul_lo_reg};
    assign mul_round = mul_prod + i2t_pkg::FRAC_MASK;
    assign q_floor   = mul_prod[63:24];
    assign q_ceil    = mul_round[63:24];

    assign over_nominal = ({1'b0, rms_reg} > i2t_pkg::NOMINAL);
    assign rms_below    = ({1'b0, rms_reg} < i2t_pkg::NOMINAL);
    assign acc_pos      = !acc_reg[31] && (acc_reg != 32'sd0);
    assign hold = (live_reg[0] && level_enable_reg == i2t_pkg::EN_WARN_ONLY)
               || (live_reg[1] && level_enable_reg <= i2t_pkg::EN_ALARM_MAX)
               || live_reg[2];
    assign count_step = (!hold && count_reg != i2t_pkg::CNT_MAX) ? count_reg + 31'd1 : count_reg;

    assign acc_nonneg   = !acc_reg[31];
    assign live_eval[0] = acc_nonneg && (acc_reg[30:0] >= warn_level_reg)  && level_enable_reg[0];
    assign live_eval[1] = acc_nonneg && (acc_reg[30:0] >= alarm_level_reg) && level_enable_reg[1];
    assign live_eval[2] = acc_nonneg && (acc_reg[30:0] >= trip_level_reg)  && level_enable_reg[2];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2t_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == i2t_pkg::OP_CLEAR)
                    begin
                        state_next = i2t_pkg::ST_OUT;
                    end
                    else if (check_period_reg == 16'd0)
                    begin
                        state_next = i2t_pkg::ST_FLAGS;
                    end
                    else
                    begin
                        state_next = i2t_pkg::ST_DIV;
                    end
                end
            end
            i2t_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = i2t_pkg::ST_CHECK;
                end
            end
            i2t_pkg::ST_CHECK:
            begin
                if (rem_reg == check_phase_reg && (over_nominal || acc_pos))
                begin
                    state_next = i2t_pkg::ST_MUL;
                end
                else
                begin
                    state_next = i2t_pkg::ST_FLAGS;
                end
            end
            i2t_pkg::ST_MUL:
            begin
                if (mul_last)
                begin
                    state_next = i2t_pkg::ST_MUL_DONE;
                end
            end
            i2t_pkg::ST_MUL_DONE:
            begin
                if (phase_reg == i2t_pkg::MP_VALUE)
                begin
                    state_next = i2t_pkg::ST_FLAGS;
                end
                else
                begin
                    state_next = i2t_pkg::ST_MUL;
                end
            end
            i2t_pkg::ST_FLAGS:
            begin
                state_next = i2t_pkg::ST_OUT;
            end
            i2t_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = i2t_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = i2t_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        tick_next         = tick_reg;
        count_next        = count_reg;
        acc_next          = acc_reg;
        live_next         = live_reg;
        sticky_next       = sticky_reg;
        rms_next          = rms_reg;
        ev_next           = ev_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        div_cnt_next      = div_cnt_reg;
        mul_a_next        = mul_a_reg;
        mul_hi_next       = mul_hi_reg;
        mul_lo_next       = mul_lo_reg;
        mul_cnt_next      = mul_cnt_reg;
        phase_next        = phase_reg;
        time_next         = time_reg;
        neg_next          = neg_reg;
        out_live_next     = out_live_reg;
        out_sticky_next   = out_sticky_reg;
        out_value_next    = out_value_reg;
        out_ev_next       = out_ev_reg;
        result_valid_next = result_valid_reg && !result_ready;

        case (state_reg)
            i2t_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rms_next  = rms_current;
                    ev_next   = 1'b0;
                    if (op == i2t_pkg::OP_CLEAR)
                    begin
                        live_next   = live_reg & ~clear_mask;
                        sticky_next = sticky_reg & ~clear_mask;
                    end
                    else
                    begin
                        tick_next    = tick_step;
                        dvd_next     = tick_step;
                        rem_next     = 16'd0;
                        div_cnt_next = '0;
                    end
                end
            end
            i2t_pkg::ST_DIV:
            begin
                // restoring remainder, one dividend bit a cycle
                rem_next     = div_trial[17] ? div_shift[15:0] : div_trial[15:0];
                dvd_next     = {dvd_reg[14:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            i2t_pkg::ST_CHECK:
            begin
                if (rem_reg == check_phase_reg)
                begin
                    ev_next = 1'b1;
                    if (over_nominal || acc_pos)
                    begin
                        count_next   = count_step;
                        mul_a_next   = {1'b0, sample_time_reg};
                        mul_hi_next  = '0;
                        mul_lo_next  = {1'b0, count_step};
                        mul_cnt_next = '0;
                        phase_next   = i2t_pkg::MP_TIME;
                    end
                    else
                    begin
                        count_next = '0;
                        acc_next   = 32'sd0;
                    end
                end
            end
            i2t_pkg::ST_MUL:
            begin
                mul_hi_next  = mul_sum[MW:1];
                mul_lo_next  = {mul_sum[0], mul_lo_reg[MW-1:1]};
                mul_cnt_next = mul_cnt_reg + 1'b1;
            end
            i2t_pkg::ST_MUL_DONE:
            begin
                mul_hi_next  = '0;
                mul_cnt_next = '0;
                case (phase_reg)
                    i2t_pkg::MP_TIME:
                    begin
                        time_next   = (|mul_prod[63:31]) ? i2t_pkg::CNT_MAX : mul_prod[30:0];
                        neg_next    = rms_below;
                        mul_a_next  = {1'b0, rms_reg} + i2t_pkg::NOMINAL;
                        mul_lo_next = rms_below ? i2t_pkg::NOMINAL - {1'b0, rms_reg}
                                                : {1'b0, rms_reg} - i2t_pkg::NOMINAL;
                        phase_next  = i2t_pkg::MP_POWER;
                    end
                    i2t_pkg::MP_POWER:
                    begin
                        // magnitude of the power term, sign kept in neg_reg
                        if (neg_reg)
                        begin
                            mul_a_next = q_ceil[31:0];
                        end
                        else
                        begin
                            mul_a_next = (|q_floor[39:31]) ? {1'b0, i2t_pkg::CNT_MAX}
                                                           : q_floor[31:0];
                        end
                        mul_lo_next = {1'b0, time_reg};
                        phase_next  = i2t_pkg::MP_VALUE;
                    end
                    i2t_pkg::MP_VALUE:
                    begin
                        if (neg_reg)
                        begin
                            if ((|q_ceil[39:32]) || (q_ceil[31] && (|q_ceil[30:0])))
                            begin
                                acc_next = {1'b1, 31'd0};
                            end
                            else
                            begin
                                acc_next = 32'sd0 - $signed(q_ceil[31:0]);
                            end
                        end
                        else
                        begin
                            acc_next = (|q_floor[39:31]) ? $signed({1'b0, i2t_pkg::CNT_MAX})
                                                         : $signed(q_floor[31:0]);
                        end
                    end
                    default:
                    begin
                        phase_next = i2t_pkg::MP_TIME;
                    end
                endcase
            end
            i2t_pkg::ST_FLAGS:
            begin
                if (ev_reg)
                begin
                    live_next   = live_eval;
                    sticky_next = sticky_reg | live_eval;
                end
                else
                begin
                    sticky_next = sticky_reg | live_reg;
                end
            end
            i2t_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_live_next     = live_reg;
                    out_sticky_next   = sticky_reg;
                    out_value_next    = acc_reg;
                    out_ev_next       = ev_reg;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                ev_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= i2t_pkg::ST_IDLE;
            tick_reg         <= '0;
            count_reg        <= '0;
            acc_reg          <= '0;
            live_reg         <= '0;
            sticky_reg       <= '0;
            result_valid_reg <= 1'b0;
            cycle_length_reg <= i2t_pkg::CYCLE_LENGTH_RST;
            check_period_reg <= i2t_pkg::CHECK_PERIOD_RST;
            check_phase_reg  <= '0;
            warn_level_reg   <= i2t_pkg::LEVEL_RST;
            alarm_level_reg  <= i2t_pkg::LEVEL_RST;
            trip_level_reg   <= i2t_pkg::LEVEL_RST;
            level_enable_reg <= '0;
            sample_time_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_reg         <= tick_next;
            count_reg        <= count_next;
            acc_reg          <= acc_next;
            live_reg         <= live_next;
            sticky_reg       <= sticky_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    i2t_pkg::CFG_CYCLE_LENGTH: cycle_length_reg <= cfg_data[15:0];
                    i2t_pkg::CFG_CHECK_PERIOD: check_period_reg <= cfg_data[15:0];
                    i2t_pkg::CFG_CHECK_PHASE:  check_phase_reg  <= cfg_data[15:0];
                    i2t_pkg::CFG_WARN_LEVEL:   warn_level_reg   <= cfg_data;
                    i2t_pkg::CFG_ALARM_LEVEL:  alarm_level_reg  <= cfg_data;
                    i2t_pkg::CFG_TRIP_LEVEL:   trip_level_reg   <= cfg_data;
                    i2t_pkg::CFG_LEVEL_ENABLE: level_enable_reg <= cfg_data[2:0];
                    i2t_pkg::CFG_SAMPLE_TIME:  sample_time_reg  <= cfg_data;
                    default:                   level_enable_reg <= level_enable_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rms_reg        <= rms_next;
        ev_reg         <= ev_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        div_cnt_reg    <= div_cnt_next;
        mul_a_reg      <= mul_a_next;
        mul_hi_reg     <= mul_hi_next;
        mul_lo_reg     <= mul_lo_next;
        mul_cnt_reg    <= mul_cnt_next;
        phase_reg      <= phase_next;
        time_reg       <= time_next;
        neg_reg        <= neg_next;
        out_live_reg   <= out_live_next;
        out_sticky_reg <= out_sticky_next;
        out_value_reg  <= out_value_next;
        out_ev_reg     <= out_ev_next;
    end

    assign result_valid   = result_valid_reg;
    assign live_flags     = out_live_reg;
    assign sticky_flags   = out_sticky_reg;
    assign overload_value = out_value_reg;
    assign evaluated      = out_ev_reg;

endmodule
